// File: hdl/acs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and constants of the accumulator processor step block.
// ----------------------------------------------------------------------------
package acs_pkg;

	localparam int PROG_DEPTH = 192;
	localparam int RAM_DEPTH  = 64;
	localparam int PROG_AW    = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
	localparam int RAM_AW     = $clog2(RAM_DEPTH);
	localparam logic [8:0] PROG_LIMIT = 9'(PROG_DEPTH);
	localparam logic [1:0] RAM_PAGE   = 2'b11;

	typedef enum logic [1:0] {
		ITEM_LOAD = 2'd0,
		ITEM_STEP = 2'd1,
		ITEM_READ = 2'd2,
		ITEM_NONE = 2'd3
	} item_op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_HALT   = 3'd1,
		ST_BADOP  = 3'd2,
		ST_BADSTA = 3'd3,
		ST_STOP   = 3'd4
	} status_t;

	typedef enum logic [7:0] {
		OP_JMP  = 8'h00,
		OP_JIZ  = 8'h02,
		OP_JNZ  = 8'h03,
		OP_JIC  = 8'h04,
		OP_JNC  = 8'h05,
		OP_JIN  = 8'h06,
		OP_JNN  = 8'h07,
		OP_AND  = 8'h09,
		OP_OR   = 8'h0A,
		OP_XOR  = 8'h0B,
		OP_INC  = 8'h0C,
		OP_DEC  = 8'h0D,
		OP_SHL  = 8'h0E,
		OP_SHR  = 8'h0F,
		OP_ADDM = 8'h10,
		OP_SUBM = 8'h11,
		OP_ADCM = 8'h12,
		OP_LDAM = 8'h16,
		OP_STA  = 8'h17,
		OP_ADD  = 8'h18,
		OP_SUB  = 8'h19,
		OP_ADC  = 8'h1A,
		OP_LDA  = 8'h1E,
		OP_HLT  = 8'h1F
	} opcode_t;

	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_RAM  = 2'd1,
		SRC_PROG = 2'd2
	} opnd_src_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_FETCH = 2'd1,
		S_EXEC  = 2'd2,
		S_FIN   = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic opnd_rd;
		logic exec_en;
		logic fin_en;
	} acs_cmd_t;

	function automatic logic prog_in_range(input logic [7:0] addr);
		return {1'b0, addr} < PROG_LIMIT;
	endfunction

	function automatic logic is_ram_addr(input logic [7:0] addr);
		return addr[7:6] == RAM_PAGE;
	endfunction

endpackage

// File: hdl/acs_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_item_if
// Input item channel: valid/ready handshake with the item payload.
// ----------------------------------------------------------------------------
interface acs_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] word_address;
	logic [7:0] load_opcode;
	logic [7:0] load_operand;

	modport source (output valid, output operation, output word_address,
		output load_opcode, output load_operand, input ready);
	modport sink (input valid, input operation, input word_address,
		input load_opcode, input load_operand, output ready);
endinterface

// File: hdl/acs_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_result_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface acs_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] program_counter;
	logic [7:0] accumulator;
	logic       carry_flag;
	logic [7:0] read_value;

	modport source (output valid, output status, output program_counter,
		output accumulator, output carry_flag, output read_value, input ready);
	modport sink (input valid, input status, input program_counter,
		input accumulator, input carry_flag, input read_value, output ready);
endinterface

// File: hdl/acs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_ctrl
// Sequencer: handshakes, item flow and datapath commands.
// ----------------------------------------------------------------------------
module acs_ctrl
	import acs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] operation,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output acs_cmd_t   cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        in_fire;
	logic        done;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		done        = 1'b0;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_FETCH: begin
				cmd.opnd_rd = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				in_ready    = out_free;
				done        = out_free;
				cmd.exec_en = out_free;
			end
			S_FIN: begin
				in_ready   = out_free;
				done       = out_free;
				cmd.fin_en = out_free;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.accept = in_fire;
		if (done) begin
			state_d = S_IDLE;
		end
		if (in_fire) begin
			state_d = (item_op_t'(operation) == ITEM_STEP) ? S_FETCH : S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_fetch_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |=> state_q == S_EXEC)
		else $error("fetch not followed by execute");

	a_step_enters_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && item_op_t'(operation) == ITEM_STEP |=> state_q == S_FETCH)
		else $error("step transfer did not start a fetch");

	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("finished item left no result");

	a_busy_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && state_q != S_IDLE |-> out_free && (cmd.exec_en || cmd.fin_en))
		else $error("item taken while the result register is occupied");

endmodule

// File: hdl/acs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acs_dp
// Datapath: program and data memories, pc, accumulator, carry, alu and
// result register.
// ----------------------------------------------------------------------------
module acs_dp
	import acs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  acs_cmd_t   cmd,
	input  logic [1:0] operation,
	input  logic [7:0] word_address,
	input  logic [7:0] load_opcode,
	input  logic [7:0] load_operand,
	output logic [2:0] status,
	output logic [7:0] program_counter,
	output logic [7:0] accumulator,
	output logic       carry_flag,
	output logic [7:0] read_value
);

	logic [7:0]            pc_q;
	logic [7:0]            acc_q;
	logic                  carry_q;
	logic                  stopped_q;
	item_op_t              op_q;

	logic [15:0]           prog_mem [PROG_DEPTH];
	logic [PROG_DEPTH-1:0] prog_vld_q;
	logic [15:0]           prog_rd_q;
	logic                  prog_rd_vld_q;
	logic                  prog_we;
	logic                  prog_re;
	logic [7:0]            prog_ra;

	logic [7:0]            ram_mem [RAM_DEPTH];
	logic [RAM_DEPTH-1:0]  ram_vld_q;
	logic [7:0]            ram_rd_q;
	logic                  ram_rd_vld_q;
	logic                  ram_we;
	logic                  ram_re;
	logic [RAM_AW-1:0]     ram_wa;
	logic [RAM_AW-1:0]     ram_ra;
	logic                  ram_fwd;

	logic [7:0]            fetch_opc;
	logic [7:0]            fetch_opd;
	logic [7:0]            ir_opc_q;
	logic [7:0]            ir_opd_q;
	opnd_src_t             src_q;

	logic [7:0]            mem_val;
	logic                  blocked;
	logic                  jump;
	logic                  advance;
	logic                  use_add;
	logic                  sta_wr;
	logic [7:0]            add_x;
	logic                  add_ci;
	logic [8:0]            sum;
	logic [7:0]            nxt_pc;
	logic [7:0]            nxt_acc;
	logic                  nxt_carry;
	logic                  nxt_stop;
	status_t               nxt_status;

	logic [2:0]            out_status_q;
	logic [7:0]            out_pc_q;
	logic [7:0]            out_acc_q;
	logic                  out_carry_q;
	logic [7:0]            out_rv_q;

	// instruction word as fetched, unwritten entries read as zero
	assign fetch_opc = prog_rd_vld_q ? prog_rd_q[15:8] : 8'd0;
	assign fetch_opd = prog_rd_vld_q ? prog_rd_q[7:0]  : 8'd0;

	// program memory port
	always_comb begin
		prog_we = cmd.accept && item_op_t'(operation) == ITEM_LOAD
			&& prog_in_range(word_address);
		prog_re = (cmd.accept && item_op_t'(operation) == ITEM_STEP) || cmd.opnd_rd;
		if (cmd.opnd_rd) begin
			prog_ra = fetch_opd;
		end else if (cmd.exec_en) begin
			prog_ra = nxt_pc;
		end else begin
			prog_ra = pc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (prog_we) begin
			prog_mem[word_address[PROG_AW-1:0]] <= {load_opcode, load_operand};
		end
		if (prog_re) begin
			prog_rd_q <= prog_mem[prog_ra[PROG_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_vld_q    <= '0;
			prog_rd_vld_q <= 1'b0;
		end else begin
			if (prog_we) begin
				prog_vld_q[word_address[PROG_AW-1:0]] <= 1'b1;
			end
			if (prog_re) begin
				prog_rd_vld_q <= prog_in_range(prog_ra)
					&& prog_vld_q[prog_ra[PROG_AW-1:0]];
			end
		end
	end

	// data ram port, write-first on a same-address read
	always_comb begin
		ram_we  = cmd.exec_en && sta_wr;
		ram_wa  = ir_opd_q[RAM_AW-1:0];
		ram_re  = (cmd.accept && item_op_t'(operation) == ITEM_READ)
			|| (cmd.opnd_rd && is_ram_addr(fetch_opd));
		ram_ra  = cmd.opnd_rd ? fetch_opd[RAM_AW-1:0] : word_address[RAM_AW-1:0];
		ram_fwd = ram_we && ram_wa == ram_ra;
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			ram_mem[ram_wa] <= acc_q;
		end
		if (ram_re) begin
			ram_rd_q <= ram_fwd ? acc_q : ram_mem[ram_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q    <= '0;
			ram_rd_vld_q <= 1'b0;
		end else begin
			if (ram_we) begin
				ram_vld_q[ram_wa] <= 1'b1;
			end
			if (ram_re) begin
				ram_rd_vld_q <= ram_fwd || ram_vld_q[ram_ra];
			end
		end
	end

	// instruction register and operand source
	always_ff @(posedge clk) begin
		if (cmd.opnd_rd) begin
			ir_opc_q <= fetch_opc;
			ir_opd_q <= fetch_opd;
			if (is_ram_addr(fetch_opd)) begin
				src_q <= SRC_RAM;
			end else if (prog_in_range(fetch_opd)) begin
				src_q <= SRC_PROG;
			end else begin
				src_q <= SRC_ZERO;
			end
		end
		if (cmd.accept) begin
			op_q <= item_op_t'(operation);
		end
	end

	always_comb begin
		case (src_q)
			SRC_RAM:  mem_val = ram_rd_vld_q ? ram_rd_q : 8'd0;
			SRC_PROG: mem_val = prog_rd_vld_q ? prog_rd_q[7:0] : 8'd0;
			default:  mem_val = 8'd0;
		endcase
	end

	// execute
	always_comb begin
		blocked    = stopped_q || !prog_in_range(pc_q);
		jump       = 1'b0;
		advance    = 1'b1;
		use_add    = 1'b0;
		sta_wr     = 1'b0;
		add_x      = ir_opd_q;
		add_ci     = 1'b0;
		nxt_acc    = acc_q;
		nxt_carry  = carry_q;
		nxt_stop   = stopped_q;
		nxt_status = ST_OK;
		case (ir_opc_q)
			OP_JMP:  jump = 1'b1;
			OP_JIZ:  jump = acc_q == 8'd0;
			OP_JNZ:  jump = acc_q != 8'd0;
			OP_JIC:  jump = carry_q;
			OP_JNC:  jump = !carry_q;
			OP_JIN:  jump = acc_q[7];
			OP_JNN:  jump = !acc_q[7];
			OP_AND:  nxt_acc = acc_q & ir_opd_q;
			OP_OR:   nxt_acc = acc_q | ir_opd_q;
			OP_XOR:  nxt_acc = acc_q ^ ir_opd_q;
			OP_INC:  nxt_acc = acc_q + 8'd1;
			OP_DEC:  nxt_acc = acc_q - 8'd1;
			OP_SHL:  nxt_acc = {acc_q[6:0], 1'b0};
			OP_SHR:  nxt_acc = {1'b0, acc_q[7:1]};
			OP_ADD:  use_add = 1'b1;
			OP_ADDM: begin
				use_add = 1'b1;
				add_x   = mem_val;
			end
			OP_SUB: begin
				use_add = 1'b1;
				add_x   = ~ir_opd_q;
				add_ci  = 1'b1;
			end
			OP_SUBM: begin
				use_add = 1'b1;
				add_x   = ~mem_val;
				add_ci  = 1'b1;
			end
			OP_ADC: begin
				use_add = 1'b1;
				add_ci  = carry_q;
			end
			OP_ADCM: begin
				use_add = 1'b1;
				add_x   = mem_val;
				add_ci  = carry_q;
			end
			OP_LDA:  nxt_acc = ir_opd_q;
			OP_LDAM: nxt_acc = mem_val;
			OP_STA: begin
				if (is_ram_addr(ir_opd_q)) begin
					sta_wr = 1'b1;
				end else begin
					nxt_stop   = 1'b1;
					nxt_status = ST_BADSTA;
					advance    = 1'b0;
				end
			end
			OP_HLT: begin
				nxt_stop   = 1'b1;
				nxt_status = ST_HALT;
			end
			default: begin
				nxt_stop   = 1'b1;
				nxt_status = ST_BADOP;
				advance    = 1'b0;
			end
		endcase
		sum = {1'b0, acc_q} + {1'b0, add_x} + {8'd0, add_ci};
		if (use_add) begin
			nxt_acc   = sum[7:0];
			nxt_carry = sum[8];
		end
		if (!advance) begin
			nxt_pc = pc_q;
		end else if (jump) begin
			nxt_pc = ir_opd_q;
		end else begin
			nxt_pc = pc_q + 8'd1;
		end
		if (blocked) begin
			nxt_pc     = pc_q;
			nxt_acc    = acc_q;
			nxt_carry  = carry_q;
			nxt_stop   = stopped_q;
			nxt_status = ST_STOP;
			sta_wr     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 8'd0;
			acc_q     <= 8'd0;
			carry_q   <= 1'b0;
			stopped_q <= 1'b0;
		end else if (cmd.exec_en) begin
			pc_q      <= nxt_pc;
			acc_q     <= nxt_acc;
			carry_q   <= nxt_carry;
			stopped_q <= nxt_stop;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec_en) begin
			out_status_q <= nxt_status;
			out_pc_q     <= nxt_pc;
			out_acc_q    <= nxt_acc;
			out_carry_q  <= nxt_carry;
			out_rv_q     <= 8'd0;
		end else if (cmd.fin_en) begin
			out_status_q <= ST_OK;
			out_pc_q     <= pc_q;
			out_acc_q    <= acc_q;
			out_carry_q  <= carry_q;
			out_rv_q     <= (op_q == ITEM_READ && ram_rd_vld_q) ? ram_rd_q : 8'd0;
		end
	end

	assign status          = out_status_q;
	assign program_counter = out_pc_q;
	assign accumulator     = out_acc_q;
	assign carry_flag      = out_carry_q;
	assign read_value      = out_rv_q;

	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop flag cleared without reset");

	a_blocked_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec_en && blocked |=> $stable(pc_q) && $stable(acc_q) && $stable(carry_q))
		else $error("blocked step changed processor state");

endmodule

// File: hdl/accumulator_cpu_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_step_top
// 8-bit accumulator processor executing one instruction per step item.
// ----------------------------------------------------------------------------
// step item: instruction read at the transfer, operand read in the fetch
//   state (both synchronous memories), result registered in the execute state
// load and read items: result registered in the finish state
// a new item is taken in the cycle the previous result is registered
// reset clears pc, accumulator, carry, stop flag and the memory valid bits
// ----------------------------------------------------------------------------
module accumulator_cpu_step_top
	import acs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	acs_item_if.sink     item,
	acs_result_if.source result
);

	acs_cmd_t cmd;

	acs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.operation (item.operation),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	acs_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (item.operation),
		.word_address    (item.word_address),
		.load_opcode     (item.load_opcode),
		.load_operand    (item.load_operand),
		.status          (result.status),
		.program_counter (result.program_counter),
		.accumulator     (result.accumulator),
		.carry_flag      (result.carry_flag),
		.read_value      (result.read_value)
	);

endmodule
